### rtl/piso_shift_register_reader_macros.svh
// Assertion macros shared by the PISO reader RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef PISO_SHIFT_REGISTER_READER_MACROS_SVH
`define PISO_SHIFT_REGISTER_READER_MACROS_SVH

`ifndef ASSERT_OFF

// Plain property check, disabled while reset is active.
`define PSR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check, disabled while reset is active.
`define PSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define PSR_ASSERT(label, clk, rst_n, prop, msg)
`define PSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/psr_pkg.sv
// Package for the PISO shift register reader: register map, field widths,
// the configuration struct and the edge step type. No dependencies.
package psr_pkg;

    // Field widths fixed by the register map and the result channel.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int READS_W    = 8;
    localparam int BITCNT_W   = 5;
    localparam int ACC_W      = 16;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_CLOCK_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_GAP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_READS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_ACTIVE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_ACTIVE     = 3'd6;

    // Register reset values.
    localparam logic [TICK_W-1:0]   RST_PULSE_WIDTH      = 16'd10;
    localparam logic [TICK_W-1:0]   RST_LOAD_CLOCK_DELAY = 16'd0;
    localparam logic [TICK_W-1:0]   RST_READ_GAP         = 16'd1000;
    localparam logic [READS_W-1:0]  RST_STABLE_READS     = 8'd3;
    localparam logic [BITCNT_W-1:0] RST_BIT_COUNT        = 5'd8;
    localparam logic                RST_LOAD_ACTIVE      = 1'b0;
    localparam logic                RST_CLOCK_ACTIVE     = 1'b1;

    // Current configuration as seen by the sequencer.
    typedef struct packed {
        logic [TICK_W-1:0]   pulse_width;
        logic [TICK_W-1:0]   load_clock_delay;
        logic [TICK_W-1:0]   read_gap;
        logic [READS_W-1:0]  stable_reads;
        logic [BITCNT_W-1:0] bit_count;
        logic                load_active_level;
        logic                clock_active_level;
    } psr_cfg_t;

    // Position within a pulse wave.
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_FIRST,
        STEP_SECOND,
        STEP_THIRD,
        STEP_FOURTH
    } psr_step_t;

endpackage

### rtl/psr_if.sv
// Valid/ready channel interfaces of the PISO shift register reader:
// sample input, result output and configuration write. Uses psr_pkg.

// Serial sample channel, one request per timing tick.
interface psr_in_if;
    logic valid;
    logic ready;
    logic serial_level;

    modport source (output valid, output serial_level, input ready);
    modport sink   (input valid, input serial_level, output ready);
endinterface

// Result channel, one request per accepted sample.
interface psr_out_if import psr_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             load_line;
    logic             clock_line;
    logic [ACC_W-1:0] accepted_word;
    logic             word_updated;

    modport source (output valid, output load_line, output clock_line,
                    output accepted_word, output word_updated, input ready);
    modport sink   (input valid, input load_line, input clock_line,
                    input accepted_word, input word_updated, output ready);
endinterface

// Configuration write channel.
interface psr_cfg_if import psr_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/psr_cfg_regs.sv
// Configuration register file of the PISO shift register reader.
// Depends on psr_pkg and the psr_cfg_if interface.
module psr_cfg_regs import psr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    psr_cfg_if.sink       cfg,
    output psr_cfg_t      regs
);

    psr_cfg_t regs_reg;
    psr_cfg_t regs_next;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the register index; writes beyond the map are dropped.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_PULSE_WIDTH:      regs_next.pulse_width      = cfg.data;
                REG_LOAD_CLOCK_DELAY: regs_next.load_clock_delay = cfg.data;
                REG_READ_GAP:         regs_next.read_gap         = cfg.data;
                REG_STABLE_READS:     regs_next.stable_reads     = cfg.data[READS_W-1:0];
                REG_BIT_COUNT:        regs_next.bit_count        = cfg.data[BITCNT_W-1:0];
                REG_LOAD_ACTIVE:      regs_next.load_active_level  = cfg.data[0];
                REG_CLOCK_ACTIVE:     regs_next.clock_active_level = cfg.data[0];
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pulse_width        <= RST_PULSE_WIDTH;
            regs_reg.load_clock_delay   <= RST_LOAD_CLOCK_DELAY;
            regs_reg.read_gap           <= RST_READ_GAP;
            regs_reg.stable_reads       <= RST_STABLE_READS;
            regs_reg.bit_count          <= RST_BIT_COUNT;
            regs_reg.load_active_level  <= RST_LOAD_ACTIVE;
            regs_reg.clock_active_level <= RST_CLOCK_ACTIVE;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### rtl/psr_debounce.sv
// Word debouncer: accepts a finished read once it has repeated enough times.
// Depends on psr_pkg.
module psr_debounce import psr_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 finish,
    input  logic [WORD_BITS-1:0] word,
    input  logic [READS_W-1:0]   stable_reads,
    output logic [WORD_BITS-1:0] stable_word,
    output logic                 updated
);

    logic [WORD_BITS-1:0] candidate_reg;
    logic [WORD_BITS-1:0] candidate_next;
    logic [READS_W-1:0]   repeat_count_reg;
    logic [READS_W-1:0]   repeat_count_next;
    logic [WORD_BITS-1:0] stable_reg;
    logic [WORD_BITS-1:0] stable_next;

    // A new word restarts the count; enough repeats publish the candidate.
    always_comb
    begin
        candidate_next    = candidate_reg;
        repeat_count_next = repeat_count_reg;
        stable_next       = stable_reg;
        updated           = 1'b0;
        if (finish)
        begin
            if (candidate_reg != word)
            begin
                repeat_count_next = READS_W'(1);
                candidate_next    = word;
            end
            else if (repeat_count_reg < stable_reads)
            begin
                repeat_count_next = repeat_count_reg + READS_W'(1);
            end
            else
            begin
                stable_next       = candidate_reg;
                repeat_count_next = '0;
                updated           = 1'b1;
            end
        end
    end

    // The result register downstream captures the value of this tick.
    assign stable_word = stable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_reg    <= '0;
            repeat_count_reg <= '0;
            stable_reg       <= '0;
        end
        else
        begin
            candidate_reg    <= candidate_next;
            repeat_count_reg <= repeat_count_next;
            stable_reg       <= stable_next;
        end
    end

endmodule

### rtl/piso_shift_register_reader.sv
// PISO shift register reader with debounce. Every accepted sample is one
// timing tick carrying the serial output level of the external register, and
// it produces exactly one result in the next cycle: the load and clock pin
// levels after that tick, the last debounced word and an update flag. A new
// sample is taken in every cycle unless a result waits downstream; the
// sequencer counters, the edge compares and the debounce update are all
// combinational. A sample is taken in the same cycle that the previous result
// is taken, so ticks flow back to back; a waiting result holds off the input.
// Depends on psr_pkg, psr_if, psr_cfg_regs, psr_debounce and the macro header.
`include "piso_shift_register_reader_macros.svh"

module piso_shift_register_reader import psr_pkg::*;
#(
    parameter int WORD_BITS  = 16,
    parameter int TIMER_BITS = 17
)
(
    input  logic       clk,
    input  logic       rst_n,
    psr_in_if.sink     sample,
    psr_out_if.source  result,
    psr_cfg_if.sink    cfg
);

    localparam int IDX_W = $clog2(WORD_BITS + 1);
    localparam int NB_W  = (IDX_W > BITCNT_W) ? IDX_W : BITCNT_W;
    localparam int CMP_W = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;

    psr_cfg_t regs;

    logic                  read_phase_reg;
    logic                  read_phase_next;
    logic [IDX_W-1:0]      bit_index_reg;
    logic [IDX_W-1:0]      bit_index_next;
    psr_step_t             edge_step_reg;
    psr_step_t             edge_step_next;
    logic [TIMER_BITS-1:0] edge_elapsed_reg;
    logic [TIMER_BITS-1:0] edge_elapsed_next;
    logic [TIMER_BITS-1:0] gap_elapsed_reg;
    logic [TIMER_BITS-1:0] gap_elapsed_next;
    logic [WORD_BITS-1:0]  shift_word_reg;
    logic [WORD_BITS-1:0]  shift_word_next;
    logic                  load_level_reg;
    logic                  load_level_next;
    logic                  clock_level_reg;
    logic                  clock_level_next;

    logic                  accept;
    logic [TIMER_BITS-1:0] edge_inc;
    logic [TIMER_BITS-1:0] gap_inc;
    logic                  pw_passed;
    logic                  dly_passed;
    logic                  gap_passed;
    logic [NB_W-1:0]       nbits;
    logic                  finish;
    logic [WORD_BITS-1:0]  stable_word;
    logic                  updated;

    // Plain pulse sequencer outputs.
    psr_step_t             plain_step_next;
    logic                  plain_set;
    logic                  plain_active;
    logic                  plain_clear;
    logic                  plain_done;

    // Nested wave sequencer outputs.
    psr_step_t             nest_step_next;
    logic                  nest_set_load;
    logic                  nest_set_clock;
    logic                  nest_active;
    logic                  nest_clear;
    logic                  nest_done;

    logic                  out_valid_reg;

    psr_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Handshake: the result register frees up when it is taken.
    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign result.valid = out_valid_reg;

    // Saturating tick counters and the edge timing compares.
    assign edge_inc   = (edge_elapsed_reg == '1) ? edge_elapsed_reg
                                                 : edge_elapsed_reg + TIMER_BITS'(1);
    assign gap_inc    = (gap_elapsed_reg == '1) ? gap_elapsed_reg
                                                : gap_elapsed_reg + TIMER_BITS'(1);
    assign pw_passed  = CMP_W'(edge_inc) > CMP_W'(regs.pulse_width);
    assign dly_passed = CMP_W'(edge_inc) > CMP_W'(regs.load_clock_delay);
    assign gap_passed = CMP_W'(gap_inc) > CMP_W'(regs.read_gap);

    // Bit count is clamped to the word width.
    assign nbits = (NB_W'(regs.bit_count) > NB_W'(WORD_BITS)) ? NB_W'(WORD_BITS)
                                                              : NB_W'(regs.bit_count);

    // Plain pulse: active edge, inactive edge, then one closing wait.
    always_comb
    begin
        plain_step_next = edge_step_reg;
        plain_set       = 1'b0;
        plain_active    = 1'b0;
        plain_clear     = 1'b0;
        plain_done      = 1'b0;
        if (pw_passed)
        begin
            case (edge_step_reg)
                STEP_IDLE:
                begin
                    plain_set       = 1'b1;
                    plain_active    = 1'b1;
                    plain_clear     = 1'b1;
                    plain_step_next = STEP_FIRST;
                end
                STEP_FIRST:
                begin
                    plain_set       = 1'b1;
                    plain_clear     = 1'b1;
                    plain_step_next = STEP_SECOND;
                end
                default:
                begin
                    plain_done      = 1'b1;
                    plain_step_next = STEP_IDLE;
                end
            endcase
        end
    end

    // Nested wave: load on, clock on, clock off, load off, closing wait.
    always_comb
    begin
        nest_step_next = edge_step_reg;
        nest_set_load  = 1'b0;
        nest_set_clock = 1'b0;
        nest_active    = 1'b0;
        nest_clear     = 1'b0;
        nest_done      = 1'b0;
        case (edge_step_reg)
            STEP_IDLE:
            begin
                if (pw_passed)
                begin
                    nest_set_load  = 1'b1;
                    nest_active    = 1'b1;
                    nest_clear     = 1'b1;
                    nest_step_next = STEP_FIRST;
                end
            end
            STEP_FIRST:
            begin
                if (dly_passed)
                begin
                    nest_set_clock = 1'b1;
                    nest_active    = 1'b1;
                    nest_clear     = 1'b1;
                    nest_step_next = STEP_SECOND;
                end
            end
            STEP_SECOND:
            begin
                if (pw_passed)
                begin
                    nest_set_clock = 1'b1;
                    nest_clear     = 1'b1;
                    nest_step_next = STEP_THIRD;
                end
            end
            STEP_THIRD:
            begin
                if (dly_passed)
                begin
                    nest_set_load  = 1'b1;
                    nest_clear     = 1'b1;
                    nest_step_next = STEP_FOURTH;
                end
            end
            default:
            begin
                if (pw_passed)
                begin
                    nest_done      = 1'b1;
                    nest_step_next = STEP_IDLE;
                end
            end
        endcase
    end

    // Read sequencer: load pulse or nested wave, first sample, then one clock pulse per bit.
    always_comb
    begin
        read_phase_next   = read_phase_reg;
        bit_index_next    = bit_index_reg;
        edge_step_next    = edge_step_reg;
        edge_elapsed_next = edge_inc;
        gap_elapsed_next  = gap_inc;
        shift_word_next   = shift_word_reg;
        load_level_next   = load_level_reg;
        clock_level_next  = clock_level_reg;
        finish            = 1'b0;
        if (gap_passed)
        begin
            if (!read_phase_reg)
            begin
                if (bit_index_reg == '0)
                begin
                    if (regs.load_clock_delay != '0)
                    begin
                        edge_step_next = nest_step_next;
                        if (nest_clear)
                        begin
                            edge_elapsed_next = '0;
                        end
                        if (nest_set_load)
                        begin
                            load_level_next = nest_active ? regs.load_active_level
                                                          : !regs.load_active_level;
                        end
                        if (nest_set_clock)
                        begin
                            clock_level_next = nest_active ? regs.clock_active_level
                                                           : !regs.clock_active_level;
                        end
                        if (nest_done)
                        begin
                            bit_index_next = IDX_W'(1);
                        end
                    end
                    else
                    begin
                        edge_step_next = plain_step_next;
                        if (plain_clear)
                        begin
                            edge_elapsed_next = '0;
                        end
                        if (plain_set)
                        begin
                            load_level_next = plain_active ? regs.load_active_level
                                                           : !regs.load_active_level;
                        end
                        if (plain_done)
                        begin
                            bit_index_next = IDX_W'(1);
                        end
                    end
                end
                else
                begin
                    // Bit 0 is already on the serial output after the load.
                    read_phase_next = 1'b1;
                    shift_word_next = shift_word_reg | WORD_BITS'(sample.serial_level);
                    bit_index_next  = IDX_W'(1);
                end
            end
            else
            begin
                edge_step_next = plain_step_next;
                if (plain_clear)
                begin
                    edge_elapsed_next = '0;
                end
                if (plain_set)
                begin
                    clock_level_next = plain_active ? regs.clock_active_level
                                                    : !regs.clock_active_level;
                end
                if (plain_done)
                begin
                    if (NB_W'(bit_index_reg) < nbits)
                    begin
                        shift_word_next = shift_word_reg |
                            (WORD_BITS'(sample.serial_level) << bit_index_reg);
                        bit_index_next  = bit_index_reg + IDX_W'(1);
                    end
                    else
                    begin
                        // The trailing clock pulse closes the read.
                        finish           = 1'b1;
                        shift_word_next  = '0;
                        bit_index_next   = '0;
                        read_phase_next  = 1'b0;
                        gap_elapsed_next = '0;
                    end
                end
            end
        end
    end

    psr_debounce #(
        .WORD_BITS (WORD_BITS)
    ) u_debounce
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .finish       (accept && finish),
        .word         (shift_word_reg),
        .stable_reads (regs.stable_reads),
        .stable_word  (stable_word),
        .updated      (updated)
    );

    // Sequencer state advances once per accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_phase_reg   <= 1'b0;
            bit_index_reg    <= '0;
            edge_step_reg    <= STEP_IDLE;
            edge_elapsed_reg <= '1;
            gap_elapsed_reg  <= '1;
            shift_word_reg   <= '0;
            load_level_reg   <= !RST_LOAD_ACTIVE;
            clock_level_reg  <= !RST_CLOCK_ACTIVE;
        end
        else if (accept)
        begin
            read_phase_reg   <= read_phase_next;
            bit_index_reg    <= bit_index_next;
            edge_step_reg    <= edge_step_next;
            edge_elapsed_reg <= edge_elapsed_next;
            gap_elapsed_reg  <= gap_elapsed_next;
            shift_word_reg   <= shift_word_next;
            load_level_reg   <= load_level_next;
            clock_level_reg  <= clock_level_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted sample.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result.load_line     <= load_level_next;
            result.clock_line    <= clock_level_next;
            result.accepted_word <= ACC_W'(stable_word);
            result.word_updated  <= updated;
        end
    end

    // The wave never goes past its closing wait.
    `PSR_ASSERT(a_step_bound, clk, rst_n, edge_step_reg <= STEP_FOURTH, "edge step out of range")
    // Once bit 0 has been taken, the bit index is never zero.
    `PSR_ASSERT_IMPLY(a_phase_index, clk, rst_n, read_phase_reg, bit_index_reg != '0, "read phase with zero bit index")
    // Shift clocking only uses the plain pulse steps.
    `PSR_ASSERT_IMPLY(a_phase_step, clk, rst_n, read_phase_reg, (edge_step_reg == STEP_IDLE || edge_step_reg == STEP_FIRST || edge_step_reg == STEP_SECOND), "nested step during shifting")
    // A waiting result blocks new samples.
    `PSR_ASSERT_IMPLY(a_stall_block, clk, rst_n, result.valid && !result.ready, !sample.ready, "sample taken over a stalled result")

endmodule
